// ===== src/flptw_pkg.sv =====
// Shared types and constants for the four-level page table walker.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package flptw_pkg;

  // input word: one table write or one translate request
  typedef struct packed {
    logic        mode;
    logic [12:0] entry_index;
    logic [63:0] entry_data;
    logic [63:0] virt_addr;
  } in_t;

  // result word
  typedef struct packed {
    logic        ok;
    logic [51:0] phys_addr;
    logic [5:0]  access_flags;
    logic [1:0]  page_size;
  } out_t;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 4;

  localparam logic [CfgIdxW-1:0] CFG_ENABLE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_ROOT   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_NX     = 2'd2;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_XLATE = 1'b1;

  localparam logic [1:0] PS_4K = 2'd0;
  localparam logic [1:0] PS_2M = 2'd1;
  localparam logic [1:0] PS_1G = 2'd2;

  localparam logic [1:0] LVL_PML4 = 2'd0;
  localparam logic [1:0] LVL_PDPT = 2'd1;
  localparam logic [1:0] LVL_PD   = 2'd2;
  localparam logic [1:0] LVL_PT   = 2'd3;

  // entry bit positions
  localparam int PTE_P  = 0;
  localparam int PTE_W  = 1;
  localparam int PTE_U  = 2;
  localparam int PTE_WT = 3;
  localparam int PTE_CD = 4;
  localparam int PTE_PS = 7;
  localparam int PTE_G  = 8;
  localparam int PTE_NX = 63;

  localparam int EntryIdxW = 9;

  // controller to datapath
  typedef struct packed {
    logic clr_wr;
    logic accept;
    logic start;
    logic step;
    logic load_out;
    logic load_hold;
    logic out_hold_src;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_xlate;
    logic pre_fail;
    logic ent_fin;
    logic clr_last;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

// ===== src/flptw_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies; holds the table store.
`default_nettype none

module flptw_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end else begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== src/flptw_ctrl.sv =====
// Sequencer of the walker: clearing pass, idle, walk and result hold.
// Depends on flptw_pkg for the command and status structs.
`default_nettype none

module flptw_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire flptw_pkg::stat_t stat_i,
  output flptw_pkg::cmd_t      cmd_o
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_WALK  = 2'd2;
  localparam logic [1:0] S_HOLD  = 2'd3;

  logic [1:0] state_q, state_d;
  logic       fin;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    fin     = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (stat_i.is_xlate && !stat_i.pre_fail) begin
            cmd_o.start = 1'b1;
            state_d     = S_WALK;
          end else begin
            fin = 1'b1;
          end
        end
      end
      S_WALK: begin
        if (stat_i.ent_fin) begin
          fin = 1'b1;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      S_HOLD: begin
        if (stat_i.out_free) begin
          cmd_o.load_out     = 1'b1;
          cmd_o.out_hold_src = 1'b1;
          state_d            = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
    // a finished word goes straight out, or parks until the output frees up
    if (fin) begin
      if (stat_i.out_free) begin
        cmd_o.load_out = 1'b1;
        state_d        = S_IDLE;
      end else begin
        cmd_o.load_hold = 1'b1;
        state_d         = S_HOLD;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  a_walk_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> ($past(state_q) == S_IDLE || $past(state_q) == S_WALK))
    else $error("walk state entered from outside idle or walk");

endmodule

`default_nettype wire

// ===== src/flptw_dp.sv =====
// Datapath of the walker: config registers, table store, walk registers,
// entry evaluation and result/output registers. Uses flptw_pkg and flptw_ram.
`default_nettype none

module flptw_dp #(
  parameter int TABLE_PAGES = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [flptw_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [flptw_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire flptw_pkg::in_t               in_data_i,
  input  wire logic                         out_stall_i,
  output logic                              out_valid_o,
  output flptw_pkg::out_t                   out_data_o,
  input  wire flptw_pkg::cmd_t              cmd_i,
  output flptw_pkg::stat_t                  stat_o
);

  localparam int FrameW     = $clog2(TABLE_PAGES);
  localparam int Depth      = TABLE_PAGES * 512;
  localparam int AddrW      = FrameW + flptw_pkg::EntryIdxW;
  localparam int unsigned StoreWords = Depth;

  // configuration
  logic       en_q;
  logic [3:0] root_q;
  logic       nxen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q   <= 1'b0;
      root_q <= '0;
      nxen_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        flptw_pkg::CFG_ENABLE: en_q   <= cfg_data_i[0];
        flptw_pkg::CFG_ROOT:   root_q <= cfg_data_i;
        flptw_pkg::CFG_NX:     nxen_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // clearing pass counter
  logic [AddrW-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_wr) begin
      clr_cnt_q <= clr_cnt_q + AddrW'(1);
    end
  end

  // input decode
  logic        is_xlate;
  logic        idx_ok;
  logic        canon;
  logic        root_ok;
  logic [31:0] idx_ext;
  logic [39:0] root_ext;
  logic [63:0] va_in;

  assign va_in    = in_data_i.virt_addr;
  assign is_xlate = (in_data_i.mode == flptw_pkg::MODE_XLATE);
  assign idx_ext  = {19'b0, in_data_i.entry_index};
  assign idx_ok   = idx_ext < 32'(StoreWords);
  assign canon    = (va_in[63:48] == {16{va_in[47]}});
  assign root_ext = {36'b0, root_q};
  assign root_ok  = root_ext < 40'(TABLE_PAGES);

  // walk registers
  logic [63:0] va_q;
  logic [1:0]  lvl_q;
  logic        wr_q, us_q, nx_q;
  logic [63:0] ent;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_q <= flptw_pkg::LVL_PML4;
    end else if (cmd_i.start) begin
      lvl_q <= flptw_pkg::LVL_PML4;
    end else if (cmd_i.step) begin
      lvl_q <= lvl_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      va_q <= va_in;
      wr_q <= 1'b1;
      us_q <= 1'b1;
      nx_q <= 1'b0;
    end else if (cmd_i.step) begin
      wr_q <= wr_q & ent[flptw_pkg::PTE_W];
      us_q <= us_q & ent[flptw_pkg::PTE_U];
      nx_q <= nx_q | (nxen_q & ent[flptw_pkg::PTE_NX]);
    end
  end

  // entry evaluation for the current level
  logic        present, leaf, frame_ok;
  logic [39:0] nframe;
  logic [8:0]  nidx;
  logic        walk_ok;
  logic [51:0] walk_pa;
  logic [1:0]  walk_ps;
  logic [5:0]  walk_fl;

  assign present  = ent[flptw_pkg::PTE_P];
  assign nframe   = ent[51:12];
  assign frame_ok = nframe < 40'(TABLE_PAGES);

  always_comb begin
    leaf    = 1'b0;
    walk_pa = {ent[51:12], va_q[11:0]};
    walk_ps = flptw_pkg::PS_4K;
    nidx    = va_q[20:12];
    case (lvl_q)
      flptw_pkg::LVL_PML4: begin
        nidx = va_q[38:30];
      end
      flptw_pkg::LVL_PDPT: begin
        leaf    = ent[flptw_pkg::PTE_PS];
        walk_pa = {ent[51:30], va_q[29:0]};
        walk_ps = flptw_pkg::PS_1G;
        nidx    = va_q[29:21];
      end
      flptw_pkg::LVL_PD: begin
        leaf    = ent[flptw_pkg::PTE_PS];
        walk_pa = {ent[51:21], va_q[20:0]};
        walk_ps = flptw_pkg::PS_2M;
      end
      default: begin
        leaf = 1'b1;
      end
    endcase
  end

  assign walk_ok = present & leaf;
  assign walk_fl = {nx_q | (nxen_q & ent[flptw_pkg::PTE_NX]),
                    ent[flptw_pkg::PTE_G],
                    ent[flptw_pkg::PTE_CD],
                    ent[flptw_pkg::PTE_WT],
                    us_q & ent[flptw_pkg::PTE_U],
                    wr_q & ent[flptw_pkg::PTE_W]};

  // table store port
  logic             ram_we;
  logic [AddrW-1:0] ram_addr;
  logic [63:0]      ram_wdata;

  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = in_data_i.entry_data;
    if (cmd_i.clr_wr) begin
      ram_we    = 1'b1;
      ram_wdata = '0;
      ram_addr  = clr_cnt_q;
    end else if (cmd_i.accept) begin
      if (is_xlate) begin
        ram_addr = {root_ext[FrameW-1:0], va_in[47:39]};
      end else begin
        ram_we   = idx_ok;
        ram_addr = idx_ext[AddrW-1:0];
      end
    end else begin
      ram_addr = {nframe[FrameW-1:0], nidx};
    end
  end

  flptw_ram #(
    .WIDTH(64),
    .DEPTH(Depth)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ent)
  );

  // result word and output register
  flptw_pkg::out_t res_d, hold_q, out_q;
  logic            out_valid_q;

  always_comb begin
    res_d = '0;
    if (cmd_i.accept) begin
      res_d.ok = !is_xlate && idx_ok;
    end else if (walk_ok) begin
      res_d.ok           = 1'b1;
      res_d.phys_addr    = walk_pa;
      res_d.access_flags = walk_fl;
      res_d.page_size    = walk_ps;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_hold) hold_q <= res_d;
    if (cmd_i.load_out)  out_q  <= cmd_i.out_hold_src ? hold_q : res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign stat_o.is_xlate = is_xlate;
  assign stat_o.pre_fail = !en_q || !canon || !root_ok;
  assign stat_o.ent_fin  = !present || leaf || !frame_ok;
  assign stat_o.clr_last = (clr_cnt_q == AddrW'(Depth - 1));
  assign stat_o.out_free = !out_valid_q || !out_stall_i;

  a_no_step_at_leaf_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> (lvl_q != flptw_pkg::LVL_PT))
    else $error("walk stepped past the last table level");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load_out && !cmd_i.out_hold_src) |-> !(out_valid_q && out_stall_i))
    else $error("result word overwrote a stalled output word");

  a_no_out_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clr_wr |-> (!out_valid_q && !cmd_i.load_out))
    else $error("result word during table clearing pass");

endmodule

`default_nettype wire

// ===== src/four_level_page_table_walker.sv =====
// Four-level page table walker over a local table store of TABLE_PAGES frames.
// Result: a write or an early-failing translate registers its word at accept;
// a walk reads one table level per step and registers its word when it ends.
// Throughput: one write per cycle while the output does not stall; a walk holds
// off new input, paced by the dependent reads of the single-port table memory.
// Reset: registers clear, then a clearing pass zeroes the TABLE_PAGES*512
// store words while input stays stalled; config writes are taken during it.
`default_nettype none

module four_level_page_table_walker #(
  parameter int TABLE_PAGES = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [flptw_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [flptw_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire flptw_pkg::in_t                 in_data_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output flptw_pkg::out_t                     out_data_o
);

  flptw_pkg::cmd_t  cmd;
  flptw_pkg::stat_t stat;

  flptw_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  flptw_dp #(
    .TABLE_PAGES(TABLE_PAGES)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_data_i),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o),
    .cmd_i      (cmd),
    .stat_o     (stat)
  );

endmodule

`default_nettype wire

// ===== tb/walk_check_pkg.sv =====
// Scoreboard for the page table walker bench: a walk predictor over a mirror
// of the table store and the queue of result words still due.
// Depends on flptw_pkg for the word types, register indexes and entry bits.
`timescale 1ns / 1ps

package walk_check_pkg;
  import flptw_pkg::*;

  localparam int TB_TABLE_PAGES = 16;
  localparam int TB_STORE_WORDS = TB_TABLE_PAGES * 512;

  // index past the last register, the block ignores it
  localparam logic [CfgIdxW-1:0] CFG_SPARE = 2'd3;

  localparam logic [63:0] FRAME_BITS = 64'h000f_ffff_ffff_f000;
  localparam logic [63:0] BASE_2M    = 64'h000f_ffff_ffe0_0000;
  localparam logic [63:0] BASE_1G    = 64'h000f_ffff_c000_0000;

  class walk_scoreboard;
    logic [63:0] store_mirror [TB_STORE_WORDS];
    bit          walk_on;
    logic [3:0]  root_frame;
    bit          nx_on;
    out_t        due_q [$];
    int          errors;

    function new();
      foreach (store_mirror[i]) store_mirror[i] = '0;
      walk_on    = 1'b0;
      root_frame = '0;
      nx_on      = 1'b0;
      errors     = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      case (idx)
        CFG_ENABLE: walk_on    = val[0];
        CFG_ROOT:   root_frame = val[3:0];
        CFG_NX:     nx_on      = val[0];
        default: ;
      endcase
    endfunction

    function out_t walk_address(logic [63:0] va);
      out_t        res;
      logic [63:0] ent;
      logic [63:0] base;
      logic [63:0] offmask;
      logic [63:0] frame;
      logic [12:0] slot;
      bit          wr;
      bit          us;
      bit          nx;
      int          lvl;
      res   = '0;
      wr    = 1'b1;
      us    = 1'b1;
      nx    = 1'b0;
      frame = 64'(root_frame);
      if (!walk_on || va[63:48] != {16{va[47]}}) return res;
      for (lvl = 0; lvl < 4; lvl++) begin
        if (frame >= 64'(TB_TABLE_PAGES)) return res;
        slot = {frame[3:0], va[(39 - 9 * lvl) +: 9]};
        ent  = store_mirror[slot];
        if (!ent[PTE_P]) return res;
        if (!ent[PTE_W]) wr = 1'b0;
        if (!ent[PTE_U]) us = 1'b0;
        if (nx_on && ent[PTE_NX]) nx = 1'b1;
        // huge bit only counts at the second and third level
        if (lvl == LVL_PDPT && ent[PTE_PS]) begin
          base          = ent & BASE_1G;
          offmask       = 64'h3fff_ffff;
          res.page_size = PS_1G;
        end else if (lvl == LVL_PD && ent[PTE_PS]) begin
          base          = ent & BASE_2M;
          offmask       = 64'h001f_ffff;
          res.page_size = PS_2M;
        end else if (lvl == LVL_PT) begin
          base          = ent & FRAME_BITS;
          offmask       = 64'h0000_0fff;
          res.page_size = PS_4K;
        end else begin
          frame = (ent & FRAME_BITS) >> 12;
          continue;
        end
        res.ok           = 1'b1;
        res.phys_addr    = 52'(base | (va & offmask));
        res.access_flags = {nx, ent[PTE_G], ent[PTE_CD], ent[PTE_WT], us, wr};
        return res;
      end
      return res;
    endfunction

    function void note_word(in_t w);
      out_t res;
      res = '0;
      if (w.mode == MODE_WRITE) begin
        if (int'(w.entry_index) < TB_STORE_WORDS) begin
          store_mirror[w.entry_index] = w.entry_data;
          res.ok = 1'b1;
        end
      end else begin
        res = walk_address(w.virt_addr);
      end
      due_q.push_back(res);
    endfunction

    function void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $display("%0t: %s expected %h got %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_word(out_t got);
      out_t want;
      if (due_q.size() == 0) begin
        $display("%0t: result word %h with none expected", $time, got);
        errors++;
        return;
      end
      want = due_q.pop_front();
      check_field("ok", 64'(want.ok), 64'(got.ok));
      check_field("phys_addr", 64'(want.phys_addr), 64'(got.phys_addr));
      check_field("access_flags", 64'(want.access_flags), 64'(got.access_flags));
      check_field("page_size", 64'(want.page_size), 64'(got.page_size));
    endfunction

    function int words_due();
      return due_q.size();
    endfunction
  endclass

endpackage

// ===== tb/testbench.sv =====
// Top of the page table walker bench: builds table paths through the write
// port, walks them under several register settings and checks every result.
// Depends on flptw_pkg, walk_check_pkg and the four_level_page_table_walker RTL.
`timescale 1ns / 1ps

module testbench;
  import flptw_pkg::*;
  import walk_check_pkg::*;

  logic                clk_i     = 1'b0;
  logic                rst_ni    = 1'b0;
  logic                cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data  = '0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  in_t                 in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_t                out_data;

  walk_scoreboard walks;
  int             words_sent = 0;
  bit             quiet      = 1'b0;
  int             stall_pct  = 20;
  int             hold_cnt   = 0;

  four_level_page_table_walker #(
    .TABLE_PAGES(TB_TABLE_PAGES)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  always #5 clk_i = ~clk_i;

  // receiver: runs of stall and no stall, mostly short
  always @(posedge clk_i) begin
    if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
      out_stall <= 1'b1;
      hold_cnt  <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                               : $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
      hold_cnt  <= $urandom_range(0, 3);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) walks.check_word(out_data);
  end

  function automatic int pick_gap();
    int roll;
    if (quiet) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [63:0] canon_va();
    logic [63:0] va;
    va = {$urandom, $urandom};
    va[63:48] = {16{va[47]}};
    return va;
  endfunction

  // next-level table frame, now and then one outside the store
  function automatic logic [39:0] pick_table();
    logic [39:0] fr;
    if ($urandom_range(0, 19) != 0) return 40'($urandom_range(0, TB_TABLE_PAGES - 1));
    fr = 40'({$urandom, $urandom});
    if (fr < 40'(TB_TABLE_PAGES)) fr = fr + 40'(TB_TABLE_PAGES);
    return fr;
  endfunction

  // valid stays up across back-to-back words, dropped only for a gap
  task automatic send_word(in_t w);
    int gap;
    gap = pick_gap();
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    walks.note_word(w);
    words_sent++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic write_word(logic [12:0] word, logic [63:0] data);
    in_t w;
    w.mode        = MODE_WRITE;
    w.entry_index = word;
    w.entry_data  = data;
    w.virt_addr   = {$urandom, $urandom};
    send_word(w);
  endtask

  task automatic xlate_word(logic [63:0] va);
    in_t w;
    w.mode        = MODE_XLATE;
    w.entry_index = 13'($urandom);
    w.entry_data  = {$urandom, $urandom};
    w.virt_addr   = va;
    send_word(w);
  endtask

  // drain: no word in flight before the registers change
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (walks.words_due() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic apply_settings(bit en, logic [3:0] root, bit nx, bit spare);
    logic [CfgIdxW-1:0]  idx [4];
    logic [CfgDataW-1:0] val [4];
    int                  n;
    int                  k;
    idx    = '{CFG_ENABLE, CFG_ROOT, CFG_NX, CFG_SPARE};
    val[0] = {3'($urandom), en};
    val[1] = root;
    val[2] = {3'($urandom), nx};
    val[3] = 4'($urandom);
    n      = spare ? 4 : 3;
    for (k = 0; k < n; k++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      @(posedge clk_i);
      walks.set_reg(idx[k], val[k]);
    end
    cfg_we <= 1'b0;
  endtask

  // lay down a path from the current root to a leaf, then walk it
  task automatic walk_sequence();
    logic [63:0] va;
    logic [63:0] ent;
    logic [63:0] probe;
    logic [39:0] frame;
    logic [39:0] next;
    int          leaf;
    int          roll;
    int          lvl;
    va    = canon_va();
    roll  = $urandom_range(0, 9);
    leaf  = (roll < 2) ? 1 : (roll < 5) ? 2 : 3;
    frame = 40'(walks.root_frame);
    next  = '0;
    for (lvl = 0; lvl <= leaf; lvl++) begin
      if (frame >= 40'(TB_TABLE_PAGES)) break;
      ent        = {$urandom, $urandom};
      ent[PTE_P] = ($urandom_range(0, 24) != 0);
      if (lvl < leaf) begin
        next        = pick_table();
        ent[51:12]  = next;
        if (lvl != LVL_PML4) ent[PTE_PS] = 1'b0;
      end else if (lvl != LVL_PT) begin
        ent[PTE_PS] = 1'b1;
      end
      // sometimes keep whatever entry is already there
      if ($urandom_range(0, 9) != 0) write_word({frame[3:0], va[(39 - 9 * lvl) +: 9]}, ent);
      frame = next;
    end
    repeat ($urandom_range(1, 3)) begin
      probe       = va;
      probe[11:0] = 12'($urandom);
      if ($urandom_range(0, 3) == 0) probe[29:12] = 18'($urandom);
      xlate_word(probe);
    end
  endtask

  task automatic noise_word();
    case ($urandom_range(0, 2))
      0:       write_word(13'($urandom), {$urandom, $urandom});
      1:       xlate_word({$urandom, $urandom});
      default: xlate_word(canon_va());
    endcase
  endtask

  task automatic run_phase(int target);
    int stop;
    stop = words_sent + target;
    while (words_sent < stop) begin
      if ($urandom_range(0, 99) < 78) walk_sequence();
      else noise_word();
    end
  endtask

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    walks = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // root 15 -> frame 1 -> frame 2 -> frame 3, walker still off
    apply_settings(1'b0, 4'd15, 1'b1, 1'b1);
    write_word({4'd15, 9'd0}, 64'h0000_0000_0000_1007);
    write_word({4'd1, 9'd0}, 64'h0000_0000_0000_2007);
    write_word({4'd2, 9'd2}, 64'h0000_0000_0000_3007);
    // 4k leaf with every flag, huge bit ignored at the last level
    write_word({4'd3, 9'd1}, 64'h800f_ffff_ffff_f19f);
    xlate_word(64'h0000_0000_0040_1234);
    settle();
    apply_settings(1'b1, 4'd15, 1'b1, 1'b0);
    xlate_word(64'h0000_0000_0040_1234);
    xlate_word(64'h8000_0000_0040_1234);
    xlate_word(64'hffff_8000_0000_0000);
    write_word({4'd2, 9'd3}, 64'h000f_ffff_ffe0_0083);
    xlate_word(64'h0000_0000_007f_ffff);
    write_word({4'd1, 9'd1}, 64'h000f_ffff_c000_0185);
    xlate_word(64'h0000_0000_7fff_ffff);
    // huge bit on a top-level entry still points to a table
    write_word({4'd15, 9'd1}, 64'h0000_0000_0000_1087);
    xlate_word(64'h0000_0080_0040_1234);
    write_word({4'd15, 9'd2}, 64'h0000_0000_0001_0001);
    xlate_word(64'h0000_0100_0040_1234);
    write_word({4'd15, 9'd3}, 64'h000f_ffff_ffff_f003);
    xlate_word(64'h0000_0180_0040_1234);
    xlate_word(64'h0000_0000_0080_0000);
    write_word({4'd3, 9'd2}, 64'hffff_ffff_ffff_fffe);
    xlate_word(64'h0000_0000_0040_2000);
    write_word(13'h1fff, 64'hffff_ffff_ffff_ffff);
    xlate_word(64'hffff_ffff_ffff_ffff);
    write_word(13'h0000, 64'h0);
    settle();
    apply_settings(1'b1, 4'd15, 1'b0, 1'b0);
    xlate_word(64'h0000_0000_0040_1234);

    settle();
    apply_settings(1'b1, 4'($urandom), 1'b1, 1'b0);
    run_phase(200);
    settle();
    quiet = 1'b1;
    apply_settings(1'b1, 4'd0, 1'b0, 1'b0);
    run_phase(180);
    settle();
    quiet = 1'b0;
    apply_settings(1'b0, 4'd15, 1'b1, 1'b1);
    run_phase(80);
    settle();
    stall_pct = 60;
    apply_settings(1'b1, 4'd15, 1'b1, 1'b0);
    run_phase(200);
    settle();
    stall_pct = 20;
    apply_settings(1'b1, 4'($urandom), 1'b0, 1'b0);
    run_phase(200);
    settle();
    apply_settings(1'b1, 4'($urandom), 1'b1, 1'b1);
    run_phase(190);
    settle();
    repeat (16) @(posedge clk_i);

    if (walks.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
